>>> hdl/ffc_pkg.sv
// shared constants, key and operator codes and sequencer states for the calculator core
package ffc_pkg;

    // datapath width of accumulator and shown value
    localparam int VALUE_WIDTH = 32;
    // iteration counter width, one step per value bit
    localparam int CNT_W = $clog2(VALUE_WIDTH);

    // key codes on the command field
    typedef enum logic [2:0] {
        CMD_DIGIT  = 3'd0,
        CMD_CLEAR  = 3'd1,
        CMD_EQUALS = 3'd2,
        CMD_ADD    = 3'd3,
        CMD_SUB    = 3'd4,
        CMD_MUL    = 3'd5,
        CMD_DIV    = 3'd6
    } cmd_t;

    // pending operator codes
    typedef enum logic [2:0] {
        OP_NONE = 3'd0,
        OP_ADD  = 3'd1,
        OP_SUB  = 3'd2,
        OP_MUL  = 3'd3,
        OP_DIV  = 3'd4
    } op_t;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIV_ABS_A,
        ST_DIV_ABS_B,
        ST_DIV,
        ST_DIV_SIGN,
        ST_APPLY,
        ST_WRITE
    } state_t;

endpackage

>>> hdl/four_function_calculator_core.sv
// calculator core: key decode, shared add/subtract unit, shift-add multiply and restoring divide
//
//  channel | handshake            | fields
//  --------+----------------------+------------------------------
//  in      | in_valid, in_ready   | command, digit
//  out     | out_valid, out_ready | shown_value, pending_operator
//
// path from key acceptance to the result transaction with the receiver ready
// digit, clear, unused keys and a pending none, add or subtract operator: straight to write
// a pending multiply: one shift-add step per cycle on the shared adder, then apply and write
// a pending divide: sign strip, one step per bit, sign fix, then apply and write; straight
// to write when the divisor is zero; in_ready is high only while idle and a waiting result holds
// the next one in the write state; rst_n clears the control and architectural registers, sets start-new-number
module four_function_calculator_core (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic [2:0]                            command,
    input  logic [3:0]                            digit,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic signed [ffc_pkg::VALUE_WIDTH-1:0] shown_value,
    output logic [2:0]                            pending_operator
);
    import ffc_pkg::*;

    localparam int W = VALUE_WIDTH;

    state_t         state_reg, state_next;
    logic [W-1:0]   acc_reg, acc_next;
    logic [W-1:0]   entry_reg, entry_next;
    logic [2:0]     pop_reg, pop_next;
    logic           snew_reg, snew_next;
    logic [2:0]     new_op_reg, new_op_next;
    logic [W-1:0]   a_reg, a_next;
    logic [W-1:0]   b_reg, b_next;
    logic [W-1:0]   q_reg, q_next;
    logic           neg_reg, neg_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic           out_valid_reg, out_valid_next;
    logic [W-1:0]   out_value_reg, out_value_next;
    logic [2:0]     out_op_reg, out_op_next;

    logic           accept;
    logic           out_free;
    logic [W:0]     add_x, add_y, add_res;
    logic           add_sub;
    logic [W-1:0]   digit_base;
    logic [W-1:0]   digit_val;
    logic [2:0]     key_op;
    logic [W-1:0]   div_shift;

    assign in_ready         = (state_reg == ST_IDLE);
    assign accept           = in_valid && in_ready;
    assign out_free         = !out_valid_reg || out_ready;
    assign out_valid        = out_valid_reg;
    assign shown_value      = out_value_reg;
    assign pending_operator = out_op_reg;

    // digit entry: base * 10 + digit, wrapping
    assign digit_base = snew_reg ? '0 : entry_reg;
    assign digit_val  = (digit_base << 3) + (digit_base << 1) + W'(digit);

    // operator left pending by this key
    assign key_op = (command == CMD_EQUALS) ? OP_NONE
                  : 3'(command - 3'(CMD_ADD) + 3'(OP_ADD));

    // partial remainder shifted left with the next dividend bit
    assign div_shift = {a_reg[W-2:0], q_reg[W-1]};

    // shared add/subtract unit operand selection
    always_comb
    begin
        add_x   = '0;
        add_y   = '0;
        add_sub = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                add_x   = {1'b0, acc_reg};
                add_y   = {1'b0, entry_reg};
                add_sub = (pop_reg == OP_SUB);
            end
            ST_MUL:
            begin
                add_x = {1'b0, a_reg};
                add_y = {1'b0, b_reg};
            end
            ST_DIV_ABS_A, ST_DIV_SIGN:
            begin
                add_y   = {1'b0, q_reg};
                add_sub = 1'b1;
            end
            ST_DIV_ABS_B:
            begin
                add_y   = {1'b0, b_reg};
                add_sub = 1'b1;
            end
            ST_DIV:
            begin
                add_x   = {1'b0, div_shift};
                add_y   = {1'b0, b_reg};
                add_sub = 1'b1;
            end
            default:
            begin
                add_sub = 1'b0;
            end
        endcase
    end

    assign add_res = add_x + (add_sub ? ~add_y : add_y) + (W+1)'(add_sub);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_WRITE;
                    if (command >= CMD_EQUALS && command <= CMD_DIV)
                    begin
                        if (pop_reg == OP_MUL)
                            state_next = ST_MUL;
                        else if (pop_reg == OP_DIV && entry_reg != '0)
                            state_next = ST_DIV_ABS_A;
                    end
                end
            end
            ST_MUL:
            begin
                if (cnt_reg == '0)
                    state_next = ST_APPLY;
            end
            ST_DIV_ABS_A: state_next = ST_DIV_ABS_B;
            ST_DIV_ABS_B: state_next = ST_DIV;
            ST_DIV:
            begin
                if (cnt_reg == '0)
                    state_next = ST_DIV_SIGN;
            end
            ST_DIV_SIGN:  state_next = ST_APPLY;
            ST_APPLY:     state_next = ST_WRITE;
            ST_WRITE:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default:      state_next = ST_IDLE;
        endcase
    end

    // datapath and output register updates
    always_comb
    begin
        acc_next       = acc_reg;
        entry_next     = entry_reg;
        pop_next       = pop_reg;
        snew_next      = snew_reg;
        new_op_next    = new_op_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        q_next         = q_reg;
        neg_next       = neg_reg;
        cnt_next       = cnt_reg;
        out_value_next = out_value_reg;
        out_op_next    = out_op_reg;
        out_valid_next = out_valid_reg && !out_ready;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (command == CMD_DIGIT)
                    begin
                        entry_next = digit_val;
                        snew_next  = 1'b0;
                    end
                    else if (command == CMD_CLEAR)
                    begin
                        acc_next   = '0;
                        entry_next = '0;
                        pop_next   = OP_NONE;
                        snew_next  = 1'b1;
                    end
                    else if (command <= CMD_DIV)
                    begin
                        new_op_next = key_op;
                        case (pop_reg)
                            OP_ADD, OP_SUB:
                            begin
                                acc_next   = add_res[W-1:0];
                                entry_next = add_res[W-1:0];
                                pop_next   = key_op;
                                snew_next  = 1'b1;
                            end
                            OP_MUL:
                            begin
                                a_next   = '0;
                                b_next   = acc_reg;
                                q_next   = entry_reg;
                                cnt_next = CNT_W'(W - 1);
                            end
                            OP_DIV:
                            begin
                                if (entry_reg == '0)
                                begin
                                    entry_next = acc_reg;
                                    pop_next   = key_op;
                                    snew_next  = 1'b1;
                                end
                                else
                                begin
                                    a_next   = '0;
                                    b_next   = entry_reg;
                                    q_next   = acc_reg;
                                    neg_next = acc_reg[W-1] ^ entry_reg[W-1];
                                    cnt_next = CNT_W'(W - 1);
                                end
                            end
                            default:
                            begin
                                acc_next  = entry_reg;
                                pop_next  = key_op;
                                snew_next = 1'b1;
                            end
                        endcase
                    end
                end
            end
            ST_MUL:
            begin
                if (q_reg[0])
                    a_next = add_res[W-1:0];
                b_next   = b_reg << 1;
                q_next   = q_reg >> 1;
                cnt_next = cnt_reg - 1'b1;
            end
            ST_DIV_ABS_A:
            begin
                if (q_reg[W-1])
                    q_next = add_res[W-1:0];
            end
            ST_DIV_ABS_B:
            begin
                if (b_reg[W-1])
                    b_next = add_res[W-1:0];
            end
            ST_DIV:
            begin
                // restoring step: keep the difference when no borrow
                if (!add_res[W])
                    a_next = add_res[W-1:0];
                else
                    a_next = div_shift;
                q_next   = {q_reg[W-2:0], !add_res[W]};
                cnt_next = cnt_reg - 1'b1;
            end
            ST_DIV_SIGN:
            begin
                if (neg_reg)
                    q_next = add_res[W-1:0];
            end
            ST_APPLY:
            begin
                acc_next   = (pop_reg == OP_MUL) ? a_reg : q_reg;
                entry_next = (pop_reg == OP_MUL) ? a_reg : q_reg;
                pop_next   = new_op_reg;
                snew_next  = 1'b1;
            end
            ST_WRITE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_value_next = entry_reg;
                    out_op_next    = pop_reg;
                end
            end
            default:
            begin
                cnt_next = '0;
            end
        endcase
    end

    // control and architectural state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            acc_reg       <= '0;
            entry_reg     <= '0;
            pop_reg       <= OP_NONE;
            snew_reg      <= 1'b1;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            acc_reg       <= acc_next;
            entry_reg     <= entry_next;
            pop_reg       <= pop_next;
            snew_reg      <= snew_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // working and output payload registers
    always_ff @(posedge clk)
    begin
        new_op_reg    <= new_op_next;
        a_reg         <= a_next;
        b_reg         <= b_next;
        q_reg         <= q_next;
        neg_reg       <= neg_next;
        out_value_reg <= out_value_next;
        out_op_reg    <= out_op_next;
    end

    // a new result only appears out of the write state
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_WRITE))
        else $error("result loaded outside write state");

    // restoring divide keeps remainder below a non-zero divisor
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) |-> (b_reg != '0) && (a_reg < b_reg))
        else $error("divide remainder out of range");

    // iteration loops leave after the last step
    assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_MUL || state_reg == ST_DIV) && cnt_reg == '0)
        |=> (state_reg == ST_APPLY || state_reg == ST_DIV_SIGN))
        else $error("iteration loop overran");

    // applying an operation always starts a new number and goes to write
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_APPLY) |=> snew_reg && (state_reg == ST_WRITE))
        else $error("apply did not finish the transaction");

    // pending operator never holds a meaningless code
    assert property (@(posedge clk) disable iff (!rst_n)
        pop_reg <= OP_DIV)
        else $error("pending operator code out of range");

endmodule

>>> verif/tb_top.sv
// self-checking testbench for the four-function calculator core: key stimulus, display predictor
`timescale 1ns / 1ps

module tb_top;
    import ffc_pkg::*;

    localparam int VW          = VALUE_WIDTH;
    localparam int CYCLE_LIMIT = 400000;
    localparam int PHASE_KEYS  = 140;
    localparam int SETTLE      = 50;

    // the one command code that the core leaves undecoded
    localparam logic [2:0] CMD_UNUSED = 3'd7;
    localparam logic [2:0] OPERATOR_KEYS [4] = '{CMD_ADD, CMD_SUB, CMD_MUL, CMD_DIV};

    typedef struct packed {
        logic [VW-1:0] value;
        op_t           op;
    } display_t;

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_ready;
    logic [2:0]           command;
    logic [3:0]           digit;
    logic                 out_valid;
    logic                 out_ready;
    logic signed [VW-1:0] shown_value;
    logic [2:0]           pending_operator;

    // predictor copy of the calculator state
    logic [VW-1:0] calc_acc;
    logic [VW-1:0] calc_entry;
    op_t           calc_op;
    logic          calc_fresh;

    display_t display_q [$];

    int send_idle_pct    = 0;
    int recv_stall_pct   = 0;
    int keys_sent        = 0;
    int displays_checked = 0;
    int error_count      = 0;
    int cycle_count      = 0;

    four_function_calculator_core dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .command          (command),
        .digit            (digit),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .shown_value      (shown_value),
        .pending_operator (pending_operator)
    );

    // 12 ns clock
    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // run-length guard
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("%0t: timeout after %0d cycles, %0d displays outstanding",
                     $time, cycle_count, display_q.size());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // receiver back-pressure, changed on the falling edge
    always @(negedge clk)
    begin
        out_ready = ($urandom_range(99) >= recv_stall_pct);
    end

    // next display for one key, updating the predictor state
    function automatic display_t calc_key(input logic [2:0] cmd, input logic [3:0] dig);
        logic [VW-1:0] mag_a;
        logic [VW-1:0] mag_b;
        logic [VW-1:0] quot;
        display_t      d;
        case (cmd)
            CMD_DIGIT:
            begin
                if (calc_fresh)
                begin
                    calc_entry = '0;
                    calc_fresh = 1'b0;
                end
                calc_entry = calc_entry * VW'(10) + VW'(dig);
            end
            CMD_CLEAR:
            begin
                calc_acc   = '0;
                calc_entry = '0;
                calc_op    = OP_NONE;
                calc_fresh = 1'b1;
            end
            CMD_EQUALS, CMD_ADD, CMD_SUB, CMD_MUL, CMD_DIV:
            begin
                // apply the pending operation first, no precedence
                case (calc_op)
                    OP_ADD: calc_acc = calc_acc + calc_entry;
                    OP_SUB: calc_acc = calc_acc - calc_entry;
                    OP_MUL: calc_acc = calc_acc * calc_entry;
                    OP_DIV:
                    begin
                        // divide by zero keeps the accumulator, quotient truncates to zero
                        if (calc_entry != '0)
                        begin
                            mag_a    = calc_acc[VW-1] ? -calc_acc : calc_acc;
                            mag_b    = calc_entry[VW-1] ? -calc_entry : calc_entry;
                            quot     = mag_a / mag_b;
                            calc_acc = (calc_acc[VW-1] ^ calc_entry[VW-1]) ? -quot : quot;
                        end
                    end
                    default: calc_acc = calc_entry;
                endcase
                calc_entry = calc_acc;
                calc_fresh = 1'b1;
                case (cmd)
                    CMD_ADD: calc_op = OP_ADD;
                    CMD_SUB: calc_op = OP_SUB;
                    CMD_MUL: calc_op = OP_MUL;
                    CMD_DIV: calc_op = OP_DIV;
                    default: calc_op = OP_NONE;
                endcase
            end
            default: ;
        endcase
        d.value = calc_entry;
        d.op    = calc_op;
        return d;
    endfunction

    // one key transaction, with random sender gaps before it
    task automatic send_key(input logic [2:0] cmd, input logic [3:0] dig);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid = 1'b0;
            command  = 3'($urandom);
            digit    = 4'($urandom);
            @(negedge clk);
        end
        in_valid = 1'b1;
        command  = cmd;
        digit    = dig;
        do @(posedge clk); while (!in_ready);
        display_q.push_back(calc_key(cmd, dig));
        keys_sent++;
    endtask

    // sender stops until every expected display has been taken
    task automatic drain_displays();
        @(negedge clk);
        in_valid = 1'b0;
        while (display_q.size() != 0)
            @(posedge clk);
    endtask

    // one random expression: numbers of varied length joined by operators
    task automatic run_expression();
        int terms;
        int ndig;
        terms = $urandom_range(1, 5);
        if ($urandom_range(24) == 0)
            send_key(CMD_CLEAR, 4'($urandom));
        for (int t = 0; t < terms; t++)
        begin
            ndig = ($urandom_range(9) == 0) ? $urandom_range(6, 11) : $urandom_range(1, 3);
            for (int k = 0; k < ndig; k++)
            begin
                if ($urandom_range(15) == 0)
                    send_key(CMD_DIGIT, 4'($urandom_range(10, 15)));
                else
                    send_key(CMD_DIGIT, 4'($urandom_range(9)));
            end
            // occasional undecoded key as noise
            if ($urandom_range(19) == 0)
                send_key(CMD_UNUSED, 4'($urandom));
            if (t < terms - 1 || $urandom_range(3) == 0)
            begin
                send_key(OPERATOR_KEYS[$urandom_range(3)], 4'($urandom));
                if ($urandom_range(7) == 0)
                    send_key(OPERATOR_KEYS[$urandom_range(3)], 4'($urandom));
            end
            else
                send_key(CMD_EQUALS, 4'($urandom));
        end
    endtask

    task automatic run_random_keys(input int count);
        int target;
        target = keys_sent + count;
        while (keys_sent < target)
            run_expression();
    endtask

    // extremes and corner cases in one key sequence
    task automatic test_directed_keys();
        int minus_one_keys [10];
        int half_keys [5];
        minus_one_keys = '{4, 2, 9, 4, 9, 6, 7, 2, 8, 15};
        half_keys      = '{3, 2, 7, 6, 8};
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        // 256, then divide by zero leaves it alone
        send_key(CMD_DIGIT, 4'd2);
        send_key(CMD_DIGIT, 4'd5);
        send_key(CMD_DIGIT, 4'd6);
        send_key(CMD_DIV, 4'd0);
        send_key(CMD_DIGIT, 4'd0);
        send_key(CMD_MUL, 4'd0);
        // second operator in a row squares the accumulator
        send_key(CMD_MUL, 4'd0);
        // 65536 * 32768 wraps to the most negative value
        foreach (half_keys[i])
            send_key(CMD_DIGIT, 4'(half_keys[i]));
        send_key(CMD_DIV, 4'd0);
        // minus one typed as its unsigned pattern, ending on a digit above nine
        foreach (minus_one_keys[i])
            send_key(CMD_DIGIT, 4'(minus_one_keys[i]));
        // most negative over minus one stays most negative
        send_key(CMD_SUB, 4'd0);
        send_key(CMD_DIGIT, 4'd1);
        // wraps to the most positive value
        send_key(CMD_ADD, 4'd15);
        send_key(CMD_UNUSED, 4'd9);
        send_key(CMD_EQUALS, 4'd0);
        send_key(CMD_CLEAR, 4'd0);
    endtask

    task automatic test_random_no_idle();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        run_random_keys(PHASE_KEYS);
    endtask

    task automatic test_random_sender_idle();
        send_idle_pct  = 78;
        recv_stall_pct = 0;
        run_random_keys(PHASE_KEYS);
    endtask

    task automatic test_random_receiver_stall();
        send_idle_pct  = 0;
        recv_stall_pct = 78;
        run_random_keys(PHASE_KEYS);
    endtask

    task automatic test_random_both_idle();
        send_idle_pct  = 34;
        recv_stall_pct = 34;
        run_random_keys(PHASE_KEYS);
    endtask

    // sender holds off until the core has delivered everything
    task automatic test_pause_until_drained();
        send_idle_pct  = 0;
        recv_stall_pct = 50;
        for (int n = 0; n < 4; n++)
        begin
            run_expression();
            drain_displays();
        end
    endtask

    // display checker, sampled on the rising edge
    always @(posedge clk)
    begin
        display_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (display_q.size() == 0)
            begin
                $display("%0t: unexpected display transaction, value %0d operator %0d",
                         $time, shown_value, pending_operator);
                error_count++;
            end
            else
            begin
                want = display_q.pop_front();
                displays_checked++;
                if (shown_value !== want.value)
                begin
                    $display("%0t: shown_value expected %0d actual %0d",
                             $time, $signed(want.value), shown_value);
                    error_count++;
                end
                if (pending_operator !== want.op)
                begin
                    $display("%0t: pending_operator expected %0d actual %0d",
                             $time, want.op, pending_operator);
                    error_count++;
                end
            end
        end
    end

    // main sequence
    initial
    begin
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        command    = CMD_DIGIT;
        digit      = 4'd0;
        out_ready  = 1'b0;
        calc_acc   = '0;
        calc_entry = '0;
        calc_op    = OP_NONE;
        calc_fresh = 1'b1;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed_keys();
        test_random_no_idle();
        test_random_sender_idle();
        test_random_receiver_stall();
        test_random_both_idle();
        test_pause_until_drained();

        // let any stray display surface before the verdict
        drain_displays();
        recv_stall_pct = 0;
        repeat (SETTLE) @(posedge clk);

        $display("covered %0d keys: directed corners, four idle mixes and drain pauses",
                 keys_sent);
        $display("%0d displays compared, %0d mismatches", displays_checked, error_count);
        if (error_count == 0 && display_q.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
